FILE: rtl/u8d_pkg.sv
package u8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] ReplChar  = CpW'(32'h0000_FFFD);
  localparam logic [7:0]     ByteNul   = 8'h00;
  localparam logic [7:0]     ByteCr    = 8'h0D;
  localparam logic [7:0]     ContMask  = 8'hC0;
  localparam logic [7:0]     ContTag   = 8'h80;
  localparam logic [7:0]     Lead2Mask = 8'hE0;
  localparam logic [7:0]     Lead2Tag  = 8'hC0;
  localparam logic [7:0]     Lead3Mask = 8'hF0;
  localparam logic [7:0]     Lead3Tag  = 8'hE0;
  localparam logic [7:0]     Lead4Mask = 8'hF8;
  localparam logic [7:0]     Lead4Tag  = 8'hF0;

  // results caused by one byte: replacement flush count, then an optional tail
  typedef struct packed {
    logic [1:0]     repl_cnt;
    logic           tail_v;
    logic [CpW-1:0] tail_cp;
    logic           tail_repl;
  } run_t;

endpackage

FILE: rtl/u8d_decode.sv
module u8d_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      byte_in,
  output u8d_pkg::run_t   run
);
  import u8d_pkg::*;

  logic [1:0]     held_r, held_nxt;
  logic [2:0]     len_r, len_nxt;
  logic [CpW-1:0] pv_r, pv_nxt;
  logic [2:0]     held_inc;
  logic [CpW-1:0] pv_shift;
  logic           is_cont;

  assign is_cont  = (byte_in & ContMask) == ContTag;
  assign held_inc = {1'b0, held_r} + 3'd1;
  assign pv_shift = {pv_r[CpW-7:0], byte_in[5:0]};

  // next sequence state and the results for this byte
  always_comb begin
    held_nxt = held_r;
    len_nxt  = len_r;
    pv_nxt   = pv_r;
    run      = '0;
    if (held_r != 2'd0 && is_cont) begin
      if (held_inc >= len_r) begin
        run.tail_v    = 1'b1;
        run.tail_cp   = pv_shift;
        run.tail_repl = 1'b0;
        held_nxt      = 2'd0;
        len_nxt       = 3'd0;
        pv_nxt        = '0;
      end else begin
        held_nxt = held_inc[1:0];
        pv_nxt   = pv_shift;
      end
    end else begin
      // broken sequence: flush one replacement per held byte
      run.repl_cnt = held_r;
      held_nxt     = 2'd0;
      len_nxt      = 3'd0;
      pv_nxt       = '0;
      // fresh decode of the byte
      if (byte_in == ByteNul || byte_in == ByteCr) begin
        run.tail_v = 1'b0;
      end else if (!byte_in[7]) begin
        run.tail_v  = 1'b1;
        run.tail_cp = CpW'(byte_in);
      end else if ((byte_in & Lead2Mask) == Lead2Tag) begin
        held_nxt = 2'd1;
        len_nxt  = 3'd2;
        pv_nxt   = CpW'(byte_in[4:0]);
      end else if ((byte_in & Lead3Mask) == Lead3Tag) begin
        held_nxt = 2'd1;
        len_nxt  = 3'd3;
        pv_nxt   = CpW'(byte_in[3:0]);
      end else if ((byte_in & Lead4Mask) == Lead4Tag) begin
        held_nxt = 2'd1;
        len_nxt  = 3'd4;
        pv_nxt   = CpW'(byte_in[2:0]);
      end else begin
        run.tail_v    = 1'b1;
        run.tail_cp   = ReplChar;
        run.tail_repl = 1'b1;
      end
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 2'd0;
      len_r  <= 3'd0;
      pv_r   <= '0;
    end else if (step) begin
      held_r <= held_nxt;
      len_r  <= len_nxt;
      pv_r   <= pv_nxt;
    end
  end

endmodule

FILE: rtl/u8d_emit.sv
module u8d_emit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  u8d_pkg::run_t          run,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [u8d_pkg::CpW-1:0] out_code_point,
  output logic                   out_replaced,
  output logic                   out_last_of_run
);
  import u8d_pkg::*;

  logic       busy_r, busy_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       tail_v_r, tail_v_nxt;
  logic [CpW-1:0] tail_cp_r;
  logic       tail_repl_r;
  logic       fire;

  // current result: flushed replacements first, then the tail
  assign out_valid       = busy_r;
  assign out_code_point  = (cnt_r != 2'd0) ? ReplChar : tail_cp_r;
  assign out_replaced    = (cnt_r != 2'd0) ? 1'b1 : tail_repl_r;
  assign out_last_of_run = (cnt_r == 2'd0) || (cnt_r == 2'd1 && !tail_v_r);
  assign fire            = busy_r && out_ready;
  assign free            = !busy_r || (fire && out_last_of_run);

  // run bookkeeping
  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    tail_v_nxt = tail_v_r;
    if (load) begin
      busy_nxt   = (run.repl_cnt != 2'd0) || run.tail_v;
      cnt_nxt    = run.repl_cnt;
      tail_v_nxt = run.tail_v;
    end else if (fire) begin
      if (cnt_r != 2'd0) begin
        cnt_nxt  = cnt_r - 2'd1;
        busy_nxt = !out_last_of_run;
      end else begin
        tail_v_nxt = 1'b0;
        busy_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= 2'd0;
      tail_v_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      tail_v_r <= tail_v_nxt;
    end
  end

  // tail payload
  always_ff @(posedge clk) begin
    if (load) begin
      tail_cp_r   <= run.tail_cp;
      tail_repl_r <= run.tail_repl;
    end
  end

endmodule

FILE: rtl/utf8_stream_decoder.sv
// utf8_stream_decoder: byte-serial UTF-8 decoder with U+FFFD substitution.
// Input channel in_valid/in_ready/in_byte_in carries one raw text byte per
// transaction; a zero byte ends the string and flushes any open sequence.
// Result channel out_valid/out_ready carries one code point per transaction
// (out_code_point, out_replaced, out_last_of_run). A byte gives zero to four
// results; out_last_of_run marks the final result of each byte.
// A byte accepted into the input register is decoded combinationally and
// loaded into the result register as soon as that register is free.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver takes each result; a byte that flushes a broken sequence
// holds the result register until all its results (up to four) are taken.
// A one-entry input register takes the next byte while a result waits.
// When the receiver stalls, the result holds, the input register fills and
// in_ready then drops until the run in progress has been taken.
// Synchronous active-low reset clears the open sequence and empties both
// registers; no result is pending after reset.
module utf8_stream_decoder (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_byte_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [u8d_pkg::CpW-1:0] out_code_point,
  output logic                    out_replaced,
  output logic                    out_last_of_run
);
  import u8d_pkg::*;

  logic       inq_v_r, inq_v_nxt;
  logic [7:0] inq_byte_r;
  logic       free;
  logic       load;
  run_t       run;

  assign load     = inq_v_r && free;
  assign in_ready = !inq_v_r || load;

  // input register
  always_comb begin
    inq_v_nxt = inq_v_r;
    if (in_valid && in_ready) begin
      inq_v_nxt = 1'b1;
    end else if (load) begin
      inq_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_v_r <= 1'b0;
    end else begin
      inq_v_r <= inq_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte_r <= in_byte_in;
    end
  end

  u8d_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (load),
    .byte_in (inq_byte_r),
    .run     (run)
  );

  u8d_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .run             (run),
    .free            (free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_replaced    (out_replaced),
    .out_last_of_run (out_last_of_run)
  );

endmodule
